### hw/rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 8;
	localparam int OCC_W    = 4;
	localparam int STATUS_W = 2;

	// Request kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE         = 2'd0,
		ST_INSERT_FULL  = 2'd1,
		ST_REMOVE_EMPTY = 2'd2
	} status_t;

	// Controller to datapath command
	typedef struct packed {
		logic    fire;
		logic    insert;
		logic    remove;
		status_t status;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic full;
		logic empty;
	} flags_t;

endpackage

### hw/rtl/spq_ifs.sv
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic signed [spq_pkg::VALUE_W-1:0] value;
	logic        [spq_pkg::PRIO_W-1:0]  prio;

	modport source(output valid, output kind, output value, output prio, input ready);
	modport sink(input valid, input kind, input value, input prio, output ready);
endinterface

interface spq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic        [spq_pkg::STATUS_W-1:0] status;
	logic signed [spq_pkg::VALUE_W-1:0]  out_value;
	logic        [spq_pkg::PRIO_W-1:0]   out_prio;
	logic        [spq_pkg::OCC_W-1:0]    occupancy;

	modport source(output valid, output status, output out_value, output out_prio,
		output occupancy, input ready);
	modport sink(input valid, input status, input out_value, input out_prio,
		input occupancy, output ready);
endinterface

### hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue.
// Usage:
//   req carries one request word: kind (insert or remove), value and prio.
//   rsp returns exactly one word per request: status, out_value, out_prio and
//   the occupancy after the step. An insert into a full queue is dropped with
//   status insert-full; a remove from an empty queue returns status
//   remove-empty with zero data.
//   Entries are held in DEPTH cells sorted by priority; all cells compare the
//   incoming priority in parallel, so every request updates all cells at once.
//   Latency: the response is valid the cycle after the request is taken.
//   Throughput: one request per cycle while rsp.ready is high, set by the single response register.
//   Stall: while rsp is held by a low ready, req.ready stays low; a new
//   request is taken in the same cycle the waiting response is taken.
//   Reset: the queue comes up empty with no response pending.
module sorted_priority_queue #(
	parameter int DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	spq_pkg::cmd_t   cmd;
	spq_pkg::flags_t flags;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.kind     (req.kind),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.flags    (flags),
		.cmd      (cmd)
	);

	spq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (req.value),
		.prio     (req.prio),
		.flags    (flags),
		.status   (rsp.status),
		.out_value(rsp.out_value),
		.out_prio (rsp.out_prio),
		.occupancy(rsp.occupancy)
	);

endmodule

### hw/rtl/spq_datapath.sv
// Sorted cell array, entry count and result register of the priority queue.
module spq_datapath #(
	parameter int DEPTH = 8,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spq_pkg::cmd_t                       cmd,
	input  logic signed [spq_pkg::VALUE_W-1:0]  value,
	input  logic        [spq_pkg::PRIO_W-1:0]   prio,
	output spq_pkg::flags_t                     flags,
	output logic        [spq_pkg::STATUS_W-1:0] status,
	output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
	output logic        [spq_pkg::PRIO_W-1:0]   out_prio,
	output logic        [spq_pkg::OCC_W-1:0]    occupancy
);

	logic signed [spq_pkg::VALUE_W-1:0] val_q [DEPTH];
	logic        [spq_pkg::PRIO_W-1:0]  pri_q [DEPTH];
	logic        [CW-1:0]               count_q;
	logic        [CW-1:0]               count_d;
	logic        [DEPTH-1:0]            ge;
	logic        [DEPTH-1:0]            ge_prev;

	logic        [spq_pkg::STATUS_W-1:0] status_q;
	logic signed [spq_pkg::VALUE_W-1:0]  out_value_q;
	logic        [spq_pkg::PRIO_W-1:0]   out_prio_q;
	logic        [spq_pkg::OCC_W-1:0]    occupancy_q;

	// Report full and empty to the controller
	assign flags.full  = (count_q == CW'(DEPTH));
	assign flags.empty = (count_q == '0);

	// Compare every occupied cell against the incoming priority at once
	for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
		assign ge[i] = (CW'(i) < count_q) && (pri_q[i] >= prio);
		if (i == 0) begin : g_head
			assign ge_prev[i] = 1'b1;
		end else begin : g_body
			assign ge_prev[i] = ge[i-1];
		end
	end

	// Update each cell: keep, take the new entry, shift down on insert, shift up on remove
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [spq_pkg::VALUE_W-1:0] dn_val;
		logic        [spq_pkg::PRIO_W-1:0]  dn_pri;
		logic signed [spq_pkg::VALUE_W-1:0] up_val;
		logic        [spq_pkg::PRIO_W-1:0]  up_pri;

		if (i == 0) begin : g_first
			assign dn_val = value;
			assign dn_pri = prio;
		end else begin : g_rest
			assign dn_val = val_q[i-1];
			assign dn_pri = pri_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign up_val = val_q[i];
			assign up_pri = pri_q[i];
		end else begin : g_inner
			assign up_val = val_q[i+1];
			assign up_pri = pri_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert && !ge[i]) begin
				if (ge_prev[i]) begin
					val_q[i] <= value;
					pri_q[i] <= prio;
				end else begin
					val_q[i] <= dn_val;
					pri_q[i] <= dn_pri;
				end
			end else if (cmd.remove) begin
				val_q[i] <= up_val;
				pri_q[i] <= up_pri;
			end
		end
	end

	// Advance the entry count
	always_comb begin
		count_d = count_q;
		if (cmd.insert) begin
			count_d = count_q + CW'(1);
		end else if (cmd.remove) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			status_q    <= cmd.status;
			out_value_q <= cmd.remove ? val_q[0] : '0;
			out_prio_q  <= cmd.remove ? pri_q[0] : '0;
			occupancy_q <= spq_pkg::OCC_W'(count_d);
		end
	end

	assign status    = status_q;
	assign out_value = out_value_q;
	assign out_prio  = out_prio_q;
	assign occupancy = occupancy_q;

`ifndef SYNTHESIS
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> count_q == $past(count_q) + CW'(1))
		else $error("count did not advance on insert");
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove |=> count_q == $past(count_q) - CW'(1))
		else $error("count did not drop on remove");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count beyond depth");
`endif

endmodule

### hw/rtl/spq_ctrl.sv
// Handshake controller of the priority queue: result slot state and command decode.
module spq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            kind,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  spq_pkg::flags_t flags,
	output spq_pkg::cmd_t   cmd
);

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   fire;

	// Take a new word whenever the result slot is free or being drained
	assign in_ready  = (state_q == S_IDLE) || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = (state_q == S_HOLD);

	// Decode the request against the fill state
	always_comb begin
		cmd.fire   = fire;
		cmd.insert = 1'b0;
		cmd.remove = 1'b0;
		cmd.status = spq_pkg::ST_DONE;
		if (kind == spq_pkg::KIND_INSERT) begin
			cmd.insert = fire && !flags.full;
			if (flags.full) begin
				cmd.status = spq_pkg::ST_INSERT_FULL;
			end
		end else begin
			cmd.remove = fire && !flags.empty;
			if (flags.empty) begin
				cmd.status = spq_pkg::ST_REMOVE_EMPTY;
			end
		end
	end

	// Hold the result slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_ready && !fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_op_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.insert && cmd.remove))
		else $error("insert and remove at once");
	a_fire_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("accepted word left no result");
`endif

endmodule

### bench/sorted_priority_queue_checker.sv
`timescale 1ns / 100ps
// Response checker for the sorted priority queue: predicts each response word and compares it.
module sorted_priority_queue_checker
	import spq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if   req,
	spq_rsp_if   rsp,
	output int   errors,
	output int   awaiting,
	output int   checked,
	output int   dropped,
	output int   empties
);

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic        [PRIO_W-1:0]  prio;
	} entry_t;

	typedef struct {
		status_t                   status;
		logic signed [VALUE_W-1:0] value;
		logic        [PRIO_W-1:0]  prio;
		logic        [OCC_W-1:0]   occ;
	} outcome_t;

	// Predicted queue contents, head first, and responses still owed by the block
	entry_t   held_q[$];
	outcome_t owed_q[$];

	// Apply one request word to the predicted queue and return the response it earns
	function automatic outcome_t queue_step(input logic kind,
		input logic signed [VALUE_W-1:0] value, input logic [PRIO_W-1:0] prio);
		outcome_t o;
		entry_t   e;
		int       slot;
		o.status = ST_DONE;
		o.value  = '0;
		o.prio   = '0;
		if (kind == KIND_INSERT) begin
			if (held_q.size() >= DEPTH) begin
				o.status = ST_INSERT_FULL;
			end else begin
				// go behind every entry of equal or higher priority
				slot = 0;
				while (slot < held_q.size() && held_q[slot].prio >= prio)
					slot++;
				e.value = value;
				e.prio  = prio;
				held_q.insert(slot, e);
			end
		end else if (held_q.size() == 0) begin
			o.status = ST_REMOVE_EMPTY;
		end else begin
			e       = held_q.pop_front();
			o.value = e.value;
			o.prio  = e.prio;
		end
		o.occ = OCC_W'(held_q.size());
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			held_q.delete();
			owed_q.delete();
			errors   = 0;
			checked  = 0;
			dropped  = 0;
			empties  = 0;
			awaiting <= 0;
		end else begin
			// compare a taken response word with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (owed_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t: response word with no request owing one", $realtime);
				end else begin
					want = owed_q.pop_front();
					checked++;
					if (want.status == ST_INSERT_FULL)
						dropped++;
					if (want.status == ST_REMOVE_EMPTY)
						empties++;
					if (rsp.status !== want.status || rsp.out_value !== want.value ||
						rsp.out_prio !== want.prio || rsp.occupancy !== want.occ) begin
						errors++;
						if (errors <= 10) begin
							$write("%t: mismatch (expected/actual) status %0d/%0d",
								$realtime, want.status, rsp.status);
							$display(" value %0d/%0d prio %0d/%0d occupancy %0d/%0d",
								want.value, rsp.out_value, want.prio, rsp.out_prio,
								want.occ, rsp.occupancy);
						end
					end
				end
			end
			// predict the response of a taken request word
			if (req.valid && req.ready)
				owed_q.push_back(queue_step(req.kind, req.value, req.prio));
			awaiting <= owed_q.size();
		end
	end

endmodule

### bench/sorted_priority_queue_test.sv
`timescale 1ns / 100ps
// Top of the sorted priority queue test: clock, reset, request and response stimulus, verdict.
module sorted_priority_queue_test;
	import spq_pkg::*;

	localparam int DEPTH        = 8;
	localparam int RANDOM_WORDS = 750;
	localparam int CALM_WORDS   = 120;

	logic clk = 1'b0;
	logic arst_n;
	int   idle_pct;
	int   insert_pct;
	int   errors;
	int   awaiting;
	int   checked;
	int   dropped;
	int   empties;

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	sorted_priority_queue #(
		.DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	sorted_priority_queue_checker #(
		.DEPTH(DEPTH)
	) u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.awaiting(awaiting),
		.checked (checked),
		.dropped (dropped),
		.empties (empties)
	);

	always #1 clk = ~clk;

	// Bound the run
	initial begin
		#1_000_000;
		$display("sorted_priority_queue_test: done, errors");
		$finish;
	end

	// Offer one request word from a falling edge until it is taken; return at a falling edge
	task automatic send_word(input logic kind, input logic signed [VALUE_W-1:0] value,
		input logic [PRIO_W-1:0] prio);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind  <= kind;
		req_ch.value <= value;
		req_ch.prio  <= prio;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// Stall the response side in bursts
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (idle_pct != 0 && $urandom_range(99) < idle_pct / 2) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		logic              kind;
		logic [PRIO_W-1:0] prio;
		idle_pct     = 20;
		insert_pct   = 50;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind  <= KIND_INSERT;
		req_ch.value <= '0;
		req_ch.prio  <= '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// remove from empty, then fill with extremes and equal priorities
		send_word(KIND_REMOVE, 32'sh7FFF_FFFF, 8'hFF);
		send_word(KIND_INSERT, 32'sh7FFF_FFFF, 8'd0);
		send_word(KIND_INSERT, 32'sh8000_0000, 8'd255);
		send_word(KIND_INSERT, -32'sd1, 8'd128);
		send_word(KIND_INSERT, 32'sd1, 8'd128);
		send_word(KIND_INSERT, 32'sd5, 8'd255);
		send_word(KIND_INSERT, 32'sd0, 8'd0);
		send_word(KIND_INSERT, 32'sh5555_AAAA, 8'd64);
		send_word(KIND_INSERT, 32'shAAAA_5555, 8'd200);
		// full queue drops inserts of any priority
		send_word(KIND_INSERT, 32'sh1234_5678, 8'd255);
		send_word(KIND_INSERT, 32'sh0BAD_CAFE, 8'd0);
		// drain past empty
		repeat (DEPTH + 1) send_word(KIND_REMOVE, 32'sh0, 8'd0);

		// random words; the insert bias swings so the queue runs full and empty often
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 32 == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 15;
				endcase
				case ($urandom_range(2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			end
			if (i >= RANDOM_WORDS - CALM_WORDS)
				idle_pct = 0;
			kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
			// half the priorities come from a small pool to force ties
			if ($urandom_range(1)) begin
				prio = PRIO_W'($urandom);
			end else begin
				case ($urandom_range(3))
					0: prio = '0;
					1: prio = '1;
					default: prio = PRIO_W'($urandom_range(100, 103));
				endcase
			end
			send_word(kind, $urandom, prio);
		end
		req_ch.valid <= 1'b0;

		// drain owed responses, then watch for stray response words before the verdict
		wait (awaiting == 0);
		repeat (5) @(negedge clk);
		$display("%0d response words checked, %0d inserts dropped on full, %0d removes on empty",
			checked, dropped, empties);
		if (errors == 0) begin
			$display("sorted_priority_queue_test: done, clean");
		end else begin
			$display("sorted_priority_queue_test: done, errors");
		end
		$finish;
	end

endmodule
